/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/wsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 17;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned OPC_W = 4;
	localparam int unsigned FIFO_DEPTH = 2;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] RSV_MASK = 8'h70;
	localparam logic [7:0] FIN_MASK = 8'h80;
	localparam logic [7:0] OPC_MASK = 8'h0F;
	localparam logic [6:0] LEN_EXT16 = 7'h7E;
	localparam logic [6:0] LEN_EXT64 = 7'h7F;

	localparam logic [OPC_W-1:0] OP_TEXT = 4'h1;
	localparam logic [OPC_W-1:0] OP_BINARY = 4'h2;
	localparam logic [OPC_W-1:0] OP_CLOSE = 4'h8;
	localparam logic [OPC_W-1:0] OP_PING = 4'h9;
	localparam logic [OPC_W-1:0] OP_PONG = 4'hA;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_ERROR = 2'd2,
		ST_LEN_MISMATCH = 2'd3
	} status_t;

	// one classified byte, passed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] raw;
		logic [BYTE_W-1:0] key;
		logic pay;
		logic last;
		status_t status;
		logic [OPC_W-1:0] opcode;
		logic [LEN_W-1:0] length;
	} item_t;

	function automatic logic opcode_known(input logic [OPC_W-1:0] op);
		return op inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
	endfunction

	function automatic logic first_byte_bad(input logic [7:0] b);
		return ((b & RSV_MASK) != 8'h00) || ((b & FIN_MASK) == 8'h00) ||
			!opcode_known(b[OPC_W-1:0]);
	endfunction

endpackage

`default_nettype wire

/* rtl/wsd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsd_in_if;
	import wsd_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rx_byte;
	logic buffer_end;

	modport source(output valid, output rx_byte, output buffer_end, input ready);
	modport sink(input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface wsd_out_if;
	import wsd_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] data_byte;
	logic data_valid;
	logic done_res;
	logic [1:0] status;
	logic [OPC_W-1:0] opcode;
	logic [LEN_W-1:0] payload_length;

	modport source(output valid, output data_byte, output data_valid, output done_res,
		output status, output opcode, output payload_length, input ready);
	modport sink(input valid, input data_byte, input data_valid, input done_res,
		input status, input opcode, input payload_length, output ready);
endinterface

`default_nettype wire

/* rtl/wsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_front (
	input  logic clk,
	input  logic arst_n,
	wsd_in_if.sink frame,
	input  logic full,
	output logic push,
	output wsd_pkg::item_t push_item
);
	import wsd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0] fhb_q;
	logic [6:0] slen_q;
	logic [LEN_W-1:0] elen_q;
	logic [31:0] key_q;
	logic herr_q;

	logic [7:0] b;
	logic [7:0] fhb_n;
	logic [6:0] slen_n;
	logic [LEN_W-1:0] elen_n;
	logic [31:0] key_n;
	logic herr_n;
	logic ext16;
	logic [POS_W-1:0] hdr;
	logic [POS_W-1:0] pay_start;
	logic [LEN_W-1:0] len;
	logic in_pay;
	logic [1:0] kidx;
	logic [7:0] key_byte;
	logic [POS_W:0] n;
	logic [POS_W:0] need;
	status_t st;

	assign frame.ready = !full;
	assign push = frame.valid && !full;
	assign b = frame.rx_byte;

	always_comb begin
		fhb_n = (pos_q == '0) ? b : fhb_q;
		slen_n = (pos_q == POS_W'(1)) ? b[6:0] : slen_q;
		if (pos_q == '0) begin
			herr_n = first_byte_bad(b);
		end else if (pos_q == POS_W'(1)) begin
			herr_n = herr_q || !b[7];
		end else begin
			herr_n = herr_q;
		end
		ext16 = (slen_n == LEN_EXT16);
		hdr = ext16 ? POS_W'(4) : POS_W'(2);
		pay_start = hdr + POS_W'(4);
		elen_n = (ext16 && pos_q >= POS_W'(2) && pos_q < POS_W'(4)) ?
			{elen_q[7:0], b} : elen_q;
		key_n = (pos_q >= hdr && pos_q < pay_start) ? {key_q[23:0], b} : key_q;
		len = ext16 ? elen_n : {9'd0, slen_n};
		in_pay = (pos_q >= POS_W'(2)) && !herr_n && (slen_n != LEN_EXT64) &&
			(len != '0) && (pos_q >= pay_start) &&
			((pos_q - pay_start) < {1'b0, len});
		// key byte 0 sits in the top bits
		kidx = pos_q[1:0] - pay_start[1:0];
		case (kidx)
			2'd0: key_byte = key_n[31:24];
			2'd1: key_byte = key_n[23:16];
			2'd2: key_byte = key_n[15:8];
			2'd3: key_byte = key_n[7:0];
			default: key_byte = key_n[7:0];
		endcase
	end

	always_comb begin
		n = {1'b0, pos_q} + (POS_W+1)'(1);
		need = (POS_W+1)'(len) + (POS_W+1)'(6) + (ext16 ? (POS_W+1)'(2) : '0);
		if (pos_q == '0) begin
			st = ST_INCOMPLETE;
		end else if (herr_n) begin
			st = ST_ERROR;
		end else if ((ext16 && pos_q < POS_W'(3)) ||
			(slen_n == LEN_EXT64 && pos_q < POS_W'(9))) begin
			st = ST_INCOMPLETE;
		end else if (slen_n == LEN_EXT64) begin
			st = ST_ERROR;
		end else if (len != '0 && need > n) begin
			st = ST_INCOMPLETE;
		end else if (len != '0 && need < n) begin
			st = ST_LEN_MISMATCH;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		push_item.raw = b;
		push_item.key = key_byte;
		push_item.pay = in_pay;
		push_item.last = frame.buffer_end;
		push_item.status = frame.buffer_end ? st : ST_OK;
		push_item.opcode = (frame.buffer_end && st == ST_OK) ? fhb_n[OPC_W-1:0] : '0;
		push_item.length = (frame.buffer_end && st == ST_OK) ? len : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fhb_q <= '0;
			slen_q <= '0;
			elen_q <= '0;
			key_q <= '0;
			herr_q <= 1'b0;
		end else if (push) begin
			if (frame.buffer_end) begin
				pos_q <= '0;
				fhb_q <= '0;
				slen_q <= '0;
				elen_q <= '0;
				key_q <= '0;
				herr_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				fhb_q <= fhb_n;
				slen_q <= slen_n;
				elen_q <= elen_n;
				key_q <= key_n;
				herr_q <= herr_n;
			end
		end
	end

	`ASSERT_PROP(a_pos_clear_after_last, clk, arst_n, push && frame.buffer_end |=> pos_q == '0)
	`ASSERT_NEVER(a_no_payload_in_header, clk, arst_n, push && pos_q < POS_W'(6) && in_pay)
	`ASSERT_NEVER(a_fields_only_when_ok, clk, arst_n, push && push_item.status != ST_OK && push_item.length != '0)

endmodule

`default_nettype wire

/* rtl/wsd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  wsd_pkg::item_t push_item,
	output logic full,
	input  logic pop,
	output wsd_pkg::item_t pop_item,
	output logic empty
);
	import wsd_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`ASSERT_PROP(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(FIFO_DEPTH))

endmodule

`default_nettype wire

/* rtl/wsd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  wsd_pkg::item_t pop_item,
	output logic pop,
	wsd_out_if.source result
);
	import wsd_pkg::*;

	logic out_valid_q;
	logic [BYTE_W-1:0] data_q;
	logic pay_q;
	logic done_q;
	status_t status_q;
	logic [OPC_W-1:0] opcode_q;
	logic [LEN_W-1:0] len_q;

	assign pop = !empty && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// unmask the payload byte on its way into the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= pop_item.pay ? (pop_item.raw ^ pop_item.key) : '0;
			pay_q <= pop_item.pay;
			done_q <= pop_item.last;
			status_q <= pop_item.status;
			opcode_q <= pop_item.opcode;
			len_q <= pop_item.length;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data_byte = data_q;
	assign result.data_valid = pay_q;
	assign result.done_res = done_q;
	assign result.status = 2'(status_q);
	assign result.opcode = opcode_q;
	assign result.payload_length = len_q;

	`ASSERT_NEVER(a_status_only_when_done, clk, arst_n, out_valid_q && !done_q && status_q != ST_OK)
	`ASSERT_NEVER(a_data_zero_when_idle, clk, arst_n, out_valid_q && !pay_q && data_q != '0)

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none

// websocket frame deframer: takes one received frame byte per item and gives one result item
// per byte. the front stage tracks the byte position, header fields and mask key and marks
// payload bytes and the final status on the buffer's last byte; a two-entry queue decouples it
// from the back stage, which unmasks the payload byte into the output register. sustained rate
// is one byte per clock while the output takes results; a byte is registered in the queue and
// then in the output register before its result's valid rises, and the front keeps taking
// bytes while a result waits on a stalled output, until the queue fills. payload bytes stream
// out before the status, which rides on the last byte's result (ok, incomplete, error, length
// mismatch).
module websocket_frame_deframer (
	input  logic clk,
	input  logic arst_n,
	wsd_in_if.sink frame,
	wsd_out_if.source result
);
	import wsd_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	item_t push_item;
	item_t pop_item;

	wsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.full(full),
		.push(push),
		.push_item(push_item)
	);

	wsd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.pop_item(pop_item),
		.empty(empty)
	);

	wsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop_item(pop_item),
		.pop(pop),
		.result(result)
	);

endmodule

`default_nettype wire

/* sim/tb_websocket_frame_deframer.sv */
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
	import wsd_pkg::*;

	localparam int unsigned RESET_CYCLES = 4;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned RANDOM_ITEMS = 340;
	localparam int unsigned LONG_STALL = 64;
	localparam int unsigned KEY_BYTES = 4;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [7:0] MASK_BIT = 8'h80;
	localparam logic [OPC_W-1:0] OP_NONE = 4'h0;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic data_valid;
		logic done_res;
		status_t status;
		logic [OPC_W-1:0] opcode;
		logic [LEN_W-1:0] payload_length;
	} deframe_res_t;

	typedef struct {
		logic [7:0] rx_byte;
		bit last;
		bit pinned;
		status_t st;
		logic [OPC_W-1:0] opc;
		logic [LEN_W-1:0] plen;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wsd_in_if frame_if ();
	wsd_out_if res_if ();

	websocket_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_if),
		.result(res_if)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [POS_W-1:0] pos_cnt;
	logic [7:0] hdr_byte0;
	logic [6:0] len7;
	logic [15:0] len16;
	logic [31:0] mask_word;
	logic hdr_bad;

	deframe_res_t pending_results[$];
	stim_row_t directed_rows[$];
	logic [7:0] frame_bytes[$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit stall_req = 1'b0;
	int unsigned hold_left = 0;

	function automatic bit opcode_supported(input logic [OPC_W-1:0] op);
		case (op)
			OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void clear_frame_state();
		pos_cnt = '0;
		hdr_byte0 = '0;
		len7 = '0;
		len16 = '0;
		mask_word = '0;
		hdr_bad = 1'b0;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input bit last,
		output deframe_res_t r);
		int unsigned p, n, extra, hdr, plen, k;
		logic [7:0] key_byte;
		r = '0;
		r.done_res = last;
		p = pos_cnt;
		if (p == 0) begin
			hdr_byte0 = b;
			hdr_bad = (b & RSV_MASK) != 8'h00 || (b & FIN_MASK) == 8'h00 ||
				!opcode_supported(b[OPC_W-1:0]);
		end else if (p == 1) begin
			len7 = b[6:0];
			if ((b & MASK_BIT) == 8'h00) begin
				hdr_bad = 1'b1;
			end
		end
		extra = (len7 == LEN_EXT16) ? 2 : 0;
		hdr = 2 + extra;
		if (p >= 2 && extra != 0 && p < 4) begin
			len16 = {len16[7:0], b};
		end
		if (p >= hdr && p < hdr + KEY_BYTES) begin
			mask_word = {mask_word[23:0], b};
		end
		plen = (len7 == LEN_EXT16) ? len16 : len7;
		if (p >= 2 && !hdr_bad && len7 != LEN_EXT64 && plen > 0 &&
			p >= hdr + KEY_BYTES && p - (hdr + KEY_BYTES) < plen) begin
			k = (p - (hdr + KEY_BYTES)) % KEY_BYTES;
			key_byte = mask_word[31 - 8 * k -: 8];
			r.data_byte = b ^ key_byte;
			r.data_valid = 1'b1;
		end
		if (last) begin
			n = p + 1;
			if (n < 2) begin
				r.status = ST_INCOMPLETE;
			end else if (hdr_bad) begin
				r.status = ST_ERROR;
			end else if ((len7 == LEN_EXT16 && n < 4) || (len7 == LEN_EXT64 && n < 10)) begin
				r.status = ST_INCOMPLETE;
			end else if (len7 == LEN_EXT64) begin
				r.status = ST_ERROR;
			end else if (plen > 0 && plen + hdr + KEY_BYTES > n) begin
				r.status = ST_INCOMPLETE;
			end else if (plen > 0 && plen + hdr + KEY_BYTES < n) begin
				r.status = ST_LEN_MISMATCH;
			end else begin
				r.status = ST_OK;
				r.opcode = hdr_byte0[OPC_W-1:0];
				r.payload_length = LEN_W'(plen);
			end
			clear_frame_state();
		end else if (pos_cnt != POS_MAX) begin
			pos_cnt = pos_cnt + 1'b1;
		end
	endfunction

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_row(input logic [7:0] b, input bit last, input bit pinned,
		input status_t st, input logic [OPC_W-1:0] opc, input logic [LEN_W-1:0] plen);
		stim_row_t row;
		row.rx_byte = b;
		row.last = last;
		row.pinned = pinned;
		row.st = st;
		row.opc = opc;
		row.plen = plen;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	// well-formed frames with random content, plus 64-bit lengths, broken headers, cut or padded frames and noise
	function automatic void build_random_frame();
		int unsigned kind, pick, plen, cut;
		logic [OPC_W-1:0] op;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 4))
			0: op = OP_TEXT;
			1: op = OP_BINARY;
			2: op = OP_CLOSE;
			3: op = OP_PING;
			default: op = OP_PONG;
		endcase
		if (kind < 10) begin
			repeat ($urandom_range(1, 10)) frame_bytes.push_back(rand_byte());
			return;
		end
		frame_bytes.push_back(FIN_MASK | {4'h0, op});
		if (kind < 20) begin
			// 64-bit length field, cut anywhere around the ten byte header
			frame_bytes.push_back(MASK_BIT | {1'b0, LEN_EXT64});
			repeat ($urandom_range(0, 14)) frame_bytes.push_back(rand_byte());
			return;
		end
		pick = $urandom_range(0, 19);
		if (pick < 12) begin
			plen = $urandom_range(0, 12);
		end else if (pick < 14) begin
			plen = $urandom_range(100, 125);
		end else if (pick < 19) begin
			plen = $urandom_range(0, 40);
		end else begin
			plen = $urandom_range(126, 300);
		end
		if (pick < 14) begin
			frame_bytes.push_back(MASK_BIT | {1'b0, 7'(plen)});
		end else begin
			frame_bytes.push_back(MASK_BIT | {1'b0, LEN_EXT16});
			frame_bytes.push_back(8'(plen >> 8));
			frame_bytes.push_back(8'(plen));
		end
		repeat (KEY_BYTES + plen) frame_bytes.push_back(rand_byte());
		if (kind < 35) begin
			case ($urandom_range(0, 2))
				0: frame_bytes[0] = rand_byte();
				1: frame_bytes[1] = frame_bytes[1] & ~MASK_BIT;
				default: frame_bytes[0] = frame_bytes[0] | (RSV_MASK & rand_byte());
			endcase
		end
		pick = $urandom_range(0, 9);
		if (pick == 7 || pick == 8) begin
			cut = $urandom_range(1, frame_bytes.size() - 1);
			repeat (cut) frame_bytes.delete(frame_bytes.size() - 1);
		end else if (pick == 9) begin
			repeat ($urandom_range(1, 4)) frame_bytes.push_back(rand_byte());
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit last, input bit pinned,
		input deframe_res_t pin_res);
		int unsigned gap;
		deframe_res_t want;
		gap = tx_calm ? 0 : (($urandom_range(0, 9) < 6) ? 0 : gap_len());
		if (gap != 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_if.valid <= 1'b1;
		frame_if.rx_byte <= b;
		frame_if.buffer_end <= last;
		@(posedge clk);
		while (frame_if.ready !== 1'b1) @(posedge clk);
		deframe_byte(b, last, want);
		pending_results.push_back(pinned ? pin_res : want);
		@(negedge clk);
	endtask

	task automatic send_frame();
		int unsigned i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
		end
	endtask

	// receiver: random hold-offs, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_left <= 0;
		end else if (stall_req) begin
			stall_req <= 1'b0;
			hold_left <= LONG_STALL;
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 3) == 0) begin
				hold_left <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		deframe_res_t got, want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.data_byte = res_if.data_byte;
			got.data_valid = res_if.data_valid;
			got.done_res = res_if.done_res;
			got.status = status_t'(res_if.status);
			got.opcode = res_if.opcode;
			got.payload_length = res_if.payload_length;
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS) begin
					$display("unexpected result item: byte %02h dv %0d done %0d st %0d",
						got.data_byte, got.data_valid, got.done_res, got.status);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS) begin
						$display("mismatch: want byte %02h dv %0d done %0d st %0d op %0h len %0d",
							want.data_byte, want.data_valid, want.done_res, want.status,
							want.opcode, want.payload_length);
						$display("          got  byte %02h dv %0d done %0d st %0d op %0h len %0d",
							got.data_byte, got.data_valid, got.done_res, got.status,
							got.opcode, got.payload_length);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned drain, rand_items;
		bit calm;
		deframe_res_t pin_res;
		frame_if.valid = 1'b0;
		frame_if.rx_byte = '0;
		frame_if.buffer_end = 1'b0;
		res_if.ready = 1'b0;
		clear_frame_state();

		// lone byte: buffer too short
		add_row(8'h81, 1, 1, ST_INCOMPLETE, OP_NONE, 16'd0);
		// rsv set, fin clear and unknown opcode all at once
		add_row(8'h73, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'h80, 1, 1, ST_ERROR, OP_NONE, 16'd0);
		// mask bit clear
		add_row(8'h8A, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'h00, 1, 1, ST_ERROR, OP_NONE, 16'd0);
		// empty ping needs no key
		add_row(8'h89, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'h80, 1, 1, ST_OK, OP_PING, 16'd0);
		// 64-bit length cut short
		add_row(8'h82, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'hFF, 1, 1, ST_INCOMPLETE, OP_NONE, 16'd0);
		// 16-bit length cut short
		add_row(8'h81, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'hFE, 0, 1, ST_OK, OP_NONE, 16'd0);
		add_row(8'h00, 1, 1, ST_INCOMPLETE, OP_NONE, 16'd0);
		// close with one payload byte and one trailing byte
		add_row(8'h88, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'h81, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'hFF, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'h00, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'hA5, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'h5A, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'hFF, 0, 0, ST_OK, OP_NONE, 16'd0);
		add_row(8'h00, 1, 0, ST_OK, OP_NONE, 16'd0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			pin_res = '0;
			pin_res.done_res = directed_rows[i].last;
			pin_res.status = directed_rows[i].st;
			pin_res.opcode = directed_rows[i].opc;
			pin_res.payload_length = directed_rows[i].plen;
			send_byte(directed_rows[i].rx_byte, directed_rows[i].last,
				directed_rows[i].pinned, pin_res);
		end

		// let the block drain completely before the back-pressure burst
		frame_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);

		// full-rate frame into a long output stall; 0xffff length, so it ends incomplete
		frame_bytes.delete();
		frame_bytes.push_back(FIN_MASK | {4'h0, OP_TEXT});
		frame_bytes.push_back(MASK_BIT | {1'b0, LEN_EXT16});
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'hFF);
		repeat (KEY_BYTES + 30) frame_bytes.push_back(rand_byte());
		tx_calm = 1'b1;
		stall_req <= 1'b1;
		send_frame();

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 9) == 0);
			tx_calm = calm;
			rx_calm <= calm;
			build_random_frame();
			rand_items += frame_bytes.size();
			send_frame();
		end
		frame_if.valid <= 1'b0;

		for (drain = 0; drain < DRAIN_LIMIT && pending_results.size() != 0; drain++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_cnt += pending_results.size();
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
